### rtl/core/ddsd_pkg.sv
package ddsd_pkg;

  typedef struct packed {
    logic signed [15:0] linear_speed;
    logic signed [15:0] angular_speed;
  } in_t;

  typedef struct packed {
    logic [11:0] left_code;
    logic [11:0] right_code;
  } out_t;

  typedef enum logic [2:0] {
    CFG_MAX_LINEAR_SPEED = 3'd0,
    CFG_MAX_TURN_RATE    = 3'd1,
    CFG_WHEEL_BASE       = 3'd2,
    CFG_WHEEL_RADIUS     = 3'd3,
    CFG_MAX_WHEEL_SPEED  = 3'd4,
    CFG_MIN_SIGNAL_VOLTS = 3'd5,
    CFG_MAX_SIGNAL_VOLTS = 3'd6,
    CFG_DAC_REF_VOLTS    = 3'd7
  } cfg_idx_e;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CODE_W     = 12;

  // one volt in signed Q8.12
  localparam logic signed [19:0] ONE_VOLT = 20'sd4096;

endpackage

### rtl/core/ddsd_div2.sv
// Two-lane pipelined restoring divider, one quotient bit per stage.
module ddsd_div2 #(
  parameter int unsigned N  = 32,
  parameter int unsigned D  = 16,
  parameter int unsigned SW = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [1:0][N-1:0]   dvd_i,
  input  logic [D-1:0]        dvs_i,
  input  logic [SW-1:0]       side_i,
  output logic                valid_o,
  output logic [1:0][N-1:0]   quo_o,
  output logic [SW-1:0]       side_o
);

  logic [1:0][D-1:0] rem_q [N];
  logic [1:0][D-1:0] rem_n [N];
  logic [1:0][N-1:0] nq_q  [N+1];
  logic [1:0][N-1:0] nq_n  [N];
  logic [1:0][D:0]   t_s   [N];
  logic [1:0]        ge_s  [N];
  logic [SW-1:0]     side_q [N+1];
  logic [N:0]        vld_q;

  // nq holds the unused dividend bits on top and the quotient bits below
  always_comb begin
    for (int k = 0; k < N; k++) begin
      for (int l = 0; l < 2; l++) begin
        t_s[k][l]   = {rem_q[k][l], nq_q[k][l][N-1]};
        ge_s[k][l]  = (t_s[k][l] >= {1'b0, dvs_i});
        rem_n[k][l] = ge_s[k][l] ? D'(t_s[k][l] - {1'b0, dvs_i}) : t_s[k][l][D-1:0];
        nq_n[k][l]  = {nq_q[k][l][N-2:0], ge_s[k][l]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[N-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= '0;
      nq_q[0]   <= dvd_i;
      side_q[0] <= side_i;
      for (int k = 1; k < N; k++) begin
        rem_q[k] <= rem_n[k-1];
      end
      for (int k = 1; k <= N; k++) begin
        nq_q[k]   <= nq_n[k-1];
        side_q[k] <= side_q[k-1];
      end
    end
  end

  assign valid_o = vld_q[N];
  assign quo_o   = nq_q[N];
  assign side_o  = side_q[N];

endmodule

### rtl/core/diff_drive_speed_to_dac.sv
// Differential drive speed command to two DAC codes. Each accepted word
// (linear and angular speed) yields one word of left and right codes; a new
// word is taken every cycle while the output buffer has room. The pipeline is
// built around three restoring divider pipelines, one quotient bit per stage:
// wheel speed over twice the radius (33 stages), control voltage over the
// wheel limit (32 stages) and DAC scaling over the reference (32 stages),
// plus the clamp, mix and window stages around them. A two-word output
// buffer lets the pipeline keep taking words while a result waits; the
// pipeline only holds when both buffer slots are full. Configuration is
// written through cfg_we_i/cfg_idx_i/cfg_wdata_i and must only change while
// no word is in flight.
module diff_drive_speed_to_dac #(
  parameter int unsigned DAC_BITS = 12
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  ddsd_pkg::in_t                         in_data_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output ddsd_pkg::out_t                        out_data_o,
  input  logic                                  cfg_we_i,
  input  logic [ddsd_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [ddsd_pkg::CFG_DATA_W-1:0]       cfg_wdata_i
);

  localparam logic [15:0] FULL16 = 16'((1 << DAC_BITS) - 1);
  localparam logic [31:0] FULL32 = {16'b0, FULL16};

  // configuration
  logic [14:0] max_lin_q, max_turn_q, max_wheel_q;
  logic [15:0] base_q, radius_q, min_volts_q, max_volts_q, ref_volts_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_lin_q   <= 15'd256;
      max_turn_q  <= 15'd1024;
      base_q      <= 16'd9830;
      radius_q    <= 16'd1966;
      max_wheel_q <= 15'd8192;
      min_volts_q <= 16'd0;
      max_volts_q <= 16'd8192;
      ref_volts_q <= 16'd13517;
    end else if (cfg_we_i) begin
      unique case (ddsd_pkg::cfg_idx_e'(cfg_idx_i))
        ddsd_pkg::CFG_MAX_LINEAR_SPEED: max_lin_q   <= cfg_wdata_i[14:0];
        ddsd_pkg::CFG_MAX_TURN_RATE:    max_turn_q  <= cfg_wdata_i[14:0];
        ddsd_pkg::CFG_WHEEL_BASE:       base_q      <= cfg_wdata_i;
        ddsd_pkg::CFG_WHEEL_RADIUS:     radius_q    <= cfg_wdata_i;
        ddsd_pkg::CFG_MAX_WHEEL_SPEED:  max_wheel_q <= cfg_wdata_i[14:0];
        ddsd_pkg::CFG_MIN_SIGNAL_VOLTS: min_volts_q <= cfg_wdata_i;
        ddsd_pkg::CFG_MAX_SIGNAL_VOLTS: max_volts_q <= cfg_wdata_i;
        ddsd_pkg::CFG_DAC_REF_VOLTS:    ref_volts_q <= cfg_wdata_i;
      endcase
    end
  end

  // zero acts as one for divisors
  logic [14:0] lim_eff;
  logic [15:0] radius_eff, ref_eff;
  assign lim_eff    = (max_wheel_q == '0) ? 15'd1 : max_wheel_q;
  assign radius_eff = (radius_q == '0) ? 16'd1 : radius_q;
  assign ref_eff    = (ref_volts_q == '0) ? 16'd1 : ref_volts_q;

  // output buffer state, sets the pipeline enable
  logic [1:0] cnt_q;
  logic       en;
  assign en         = (cnt_q != 2'd2);
  assign in_ready_o = en;

  // stage 1: clamp commands
  logic signed [16:0] lin_x, ang_x, lin_lim, ang_lim;
  logic signed [15:0] s1_v_d, s1_w_d, s1_v_q, s1_w_q;
  logic               s1_vld_q;

  always_comb begin
    lin_x   = $signed({in_data_i.linear_speed[15], in_data_i.linear_speed});
    ang_x   = $signed({in_data_i.angular_speed[15], in_data_i.angular_speed});
    lin_lim = $signed({2'b00, max_lin_q});
    ang_lim = $signed({2'b00, max_turn_q});
    priority if (lin_x < -lin_lim) s1_v_d = 16'(-lin_lim);
    else if (lin_x > lin_lim)      s1_v_d = 16'(lin_lim);
    else                           s1_v_d = 16'(lin_x);
    priority if (ang_x < -ang_lim) s1_w_d = 16'(-ang_lim);
    else if (ang_x > ang_lim)      s1_w_d = 16'(ang_lim);
    else                           s1_w_d = 16'(ang_x);
  end

  // stage 2: 2v scaled to 2^-24 and w*base
  logic signed [32:0] s2_lin_q, s2_turn_q;
  logic               s2_vld_q;

  // stage 3: wheel numerators
  logic signed [33:0] s3_num_q [2];
  logic               s3_vld_q;

  // divider A: numerator magnitude over 2*radius
  logic [1:0][32:0] a_dvd, a_quo;
  logic [1:0]       a_sgn;
  logic             a_vld;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      a_dvd[l] = s3_num_q[l][33] ? 33'(-s3_num_q[l]) : s3_num_q[l][32:0];
    end
  end

  ddsd_div2 #(.N(33), .D(17), .SW(2)) u_div_wheel (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s3_vld_q),
    .dvd_i   (a_dvd),
    .dvs_i   ({radius_eff, 1'b0}),
    .side_i  ({s3_num_q[1][33], s3_num_q[0][33]}),
    .valid_o (a_vld),
    .quo_o   (a_quo),
    .side_o  (a_sgn)
  );

  // stage 5: signed wheel speeds
  logic signed [33:0] s5_sp_q [2];
  logic               s5_vld_q;

  // stage 6: limit shift amount
  logic signed [33:0] hi, lo, lim34, s6_delta_d, s6_delta_q;
  logic signed [33:0] s6_sp_q [2];
  logic               s6_vld_q;

  always_comb begin
    hi    = (s5_sp_q[0] > s5_sp_q[1]) ? s5_sp_q[0] : s5_sp_q[1];
    lo    = (s5_sp_q[0] < s5_sp_q[1]) ? s5_sp_q[0] : s5_sp_q[1];
    lim34 = $signed({19'b0, max_wheel_q});
    priority if (hi > lim34) s6_delta_d = hi - lim34;
    else if (lo < -lim34)    s6_delta_d = lo + lim34;
    else                     s6_delta_d = '0;
  end

  // stage 7: shifted speeds
  logic signed [34:0] s7_sh_q [2];
  logic               s7_vld_q;

  // stage 8: sign and magnitude
  logic [34:0] s8_mag_q [2];
  logic [1:0]  s8_sgn_q;
  logic        s8_vld_q;

  // divider B: magnitude*4096 over limit; magnitude capped at 32*limit,
  // which already lands outside any signal window
  logic [19:0]      cap;
  logic [1:0][31:0] b_dvd, b_quo;
  logic [1:0]       b_sgn;
  logic             b_vld;

  always_comb begin
    cap = {lim_eff, 5'b0};
    for (int l = 0; l < 2; l++) begin
      b_dvd[l] = (s8_mag_q[l] > {15'b0, cap}) ? {cap, 12'b0} : {s8_mag_q[l][19:0], 12'b0};
    end
  end

  ddsd_div2 #(.N(32), .D(15), .SW(2)) u_div_volts (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s8_vld_q),
    .dvd_i   (b_dvd),
    .dvs_i   (lim_eff),
    .side_i  (s8_sgn_q),
    .valid_o (b_vld),
    .quo_o   (b_quo),
    .side_o  (b_sgn)
  );

  // stage 10: control voltage before window
  logic signed [19:0] s10_volts_q [2];
  logic               s10_vld_q;

  // stage 11: window clamp
  logic signed [19:0] min20, max20;
  logic [15:0]        s11_volts_d [2];
  logic [15:0]        s11_volts_q [2];
  logic               s11_vld_q;

  always_comb begin
    min20 = $signed({4'b0, min_volts_q});
    max20 = $signed({4'b0, max_volts_q});
    for (int l = 0; l < 2; l++) begin
      priority if (s10_volts_q[l] < min20) s11_volts_d[l] = min_volts_q;
      else if (s10_volts_q[l] > max20)     s11_volts_d[l] = max_volts_q;
      else                                 s11_volts_d[l] = s10_volts_q[l][15:0];
    end
  end

  // divider C: volts*full over reference
  logic [1:0][31:0] c_dvd, c_quo;
  logic             c_vld;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      c_dvd[l] = {16'b0, s11_volts_q[l]} * FULL32;
    end
  end

  ddsd_div2 #(.N(32), .D(16), .SW(1)) u_div_code (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s11_vld_q),
    .dvd_i   (c_dvd),
    .dvs_i   (ref_eff),
    .side_i  (1'b0),
    .valid_o (c_vld),
    .quo_o   (c_quo),
    .side_o  ()
  );

  // saturate and pack
  logic [31:0]    code_sat [2];
  ddsd_pkg::out_t push_word;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      code_sat[l] = (c_quo[l] > FULL32) ? FULL32 : c_quo[l];
    end
    push_word.left_code  = code_sat[0][ddsd_pkg::CODE_W-1:0];
    push_word.right_code = code_sat[1][ddsd_pkg::CODE_W-1:0];
  end

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      s5_vld_q  <= 1'b0;
      s6_vld_q  <= 1'b0;
      s7_vld_q  <= 1'b0;
      s8_vld_q  <= 1'b0;
      s10_vld_q <= 1'b0;
      s11_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q  <= in_valid_i;
      s2_vld_q  <= s1_vld_q;
      s3_vld_q  <= s2_vld_q;
      s5_vld_q  <= a_vld;
      s6_vld_q  <= s5_vld_q;
      s7_vld_q  <= s6_vld_q;
      s8_vld_q  <= s7_vld_q;
      s10_vld_q <= b_vld;
      s11_vld_q <= s10_vld_q;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_v_q    <= s1_v_d;
      s1_w_q    <= s1_w_d;
      s2_lin_q  <= $signed({s1_v_q, 17'b0});
      s2_turn_q <= $signed({{17{s1_w_q[15]}}, s1_w_q}) * $signed({17'b0, base_q});
      s3_num_q[0] <= {s2_lin_q[32], s2_lin_q} - {s2_turn_q[32], s2_turn_q};
      s3_num_q[1] <= {s2_lin_q[32], s2_lin_q} + {s2_turn_q[32], s2_turn_q};
      for (int l = 0; l < 2; l++) begin
        s5_sp_q[l] <= a_sgn[l] ? -$signed({1'b0, a_quo[l]}) : $signed({1'b0, a_quo[l]});
        s6_sp_q[l] <= s5_sp_q[l];
        s7_sh_q[l] <= {s6_sp_q[l][33], s6_sp_q[l]} - {s6_delta_q[33], s6_delta_q};
        s8_sgn_q[l] <= s7_sh_q[l][34];
        s8_mag_q[l] <= s7_sh_q[l][34] ? 35'(-s7_sh_q[l]) : s7_sh_q[l];
        s10_volts_q[l] <= b_sgn[l] ? ddsd_pkg::ONE_VOLT - $signed({2'b0, b_quo[l][17:0]})
                                   : ddsd_pkg::ONE_VOLT + $signed({2'b0, b_quo[l][17:0]});
        s11_volts_q[l] <= s11_volts_d[l];
      end
      s6_delta_q <= s6_delta_d;
    end
  end

  // two-word output buffer
  ddsd_pkg::out_t buf_q [2];
  logic           wr_ptr_q, rd_ptr_q;
  logic           push, pop;

  assign push        = en && c_vld;
  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o  = buf_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= 2'd0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) buf_q[wr_ptr_q] <= push_word;
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'd2)
    else $error("output buffer overflow");

  a_full_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2 && !out_ready_i) |=> !in_ready_o)
    else $error("pipeline ran while buffer full");

  a_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s11_vld_q && min_volts_q <= max_volts_q) |->
      (s11_volts_q[0] >= min_volts_q && s11_volts_q[0] <= max_volts_q &&
       s11_volts_q[1] >= min_volts_q && s11_volts_q[1] <= max_volts_q))
    else $error("control voltage outside window");
`endif

endmodule
